[rtl/brra_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brra_pkg
// Shared types, constants and index helpers for the byte ring with read-ahead.
// ----------------------------------------------------------------------------
package brra_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = IDX_W + 1;

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(STORE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(STORE_DEPTH);

    typedef enum logic [2:0] {
        CMD_PUSH       = 3'd0,
        CMD_POP        = 3'd1,
        CMD_START_READ = 3'd2,
        CMD_READ_AHEAD = 3'd3,
        CMD_END_READ   = 3'd4,
        CMD_QUERY      = 3'd5
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_ALL_READ = 2'd3
    } status_t;

    // forward distance from one index to another around the ring
    function automatic logic [LEN_W-1:0] ring_distance(
        input logic [IDX_W-1:0] from_idx,
        input logic [IDX_W-1:0] to_idx,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W-1:0] f;
        logic [LEN_W-1:0] t;
        f = {1'b0, from_idx};
        t = {1'b0, to_idx};
        if (t >= f)
            return t - f;
        else
            return t + len - f;
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(
        input logic [IDX_W-1:0] idx,
        input logic [LEN_W-1:0] len
    );
        logic [LEN_W-1:0] nxt;
        nxt = {1'b0, idx} + LEN_W'(1);
        if (nxt >= len)
            return '0;
        else
            return nxt[IDX_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] v);
        if (v < LEN_MIN)
            return LEN_MIN;
        else if (v > LEN_MAX)
            return LEN_MAX;
        else
            return v;
    endfunction

endpackage
`default_nettype wire

[rtl/byte_ring_with_read_ahead.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_with_read_ahead
// Byte ring buffer with a separate read-ahead pointer, one command per beat.
// ----------------------------------------------------------------------------
// One command is taken per clock cycle and its result appears in the output
// register on the next cycle, so the sustained rate is one beat per cycle
// while the result side does not stall. Every command reads and updates the
// three ring indices in a single pass; the byte store is a 256-entry memory
// with one write port and one registered read port. A write of the length
// register clears all indices; out-of-range lengths are clamped to 2..256.
// The usable capacity is the length minus one byte. Popping or reading an
// entry that was never pushed returns an undefined byte.
module byte_ring_with_read_ahead
    import brra_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             config_write_en,
    input  wire logic [LEN_W-1:0] config_write_data,

    input  wire logic             in_valid,
    output      logic             in_stall,
    input  wire logic [2:0]       command,
    input  wire logic [7:0]       push_data,

    output      logic             out_valid,
    input  wire logic             out_stall,
    output      logic [7:0]       data_out,
    output      logic [1:0]       status,
    output      logic [7:0]       used_count,
    output      logic [8:0]       free_count,
    output      logic [7:0]       unread_count
);

    logic [7:0]       byte_store [STORE_DEPTH];

    logic [LEN_W-1:0] length_reg;
    logic [IDX_W-1:0] write_index_reg,      write_index_next;
    logic [IDX_W-1:0] oldest_index_reg,     oldest_index_next;
    logic [IDX_W-1:0] read_ahead_index_reg, read_ahead_index_next;

    logic             out_valid_reg;
    logic             data_sel_reg,  data_sel_next;
    logic [7:0]       rd_data_reg;
    status_t          status_reg,    status_next;
    logic [7:0]       used_reg,      used_next;
    logic [8:0]       free_reg,      free_next;
    logic [7:0]       unread_reg,    unread_next;

    logic             in_accept;
    logic             mem_we;
    logic [IDX_W-1:0] rd_addr;
    logic [LEN_W-1:0] used_cur;
    logic [LEN_W-1:0] done_cur;
    logic [LEN_W-1:0] used_new;
    logic [LEN_W-1:0] done_new;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // command decode and index update
    always_comb
    begin
        write_index_next      = write_index_reg;
        oldest_index_next     = oldest_index_reg;
        read_ahead_index_next = read_ahead_index_reg;
        status_next           = STATUS_OK;
        data_sel_next         = 1'b0;
        mem_we                = 1'b0;
        rd_addr               = oldest_index_reg;

        used_cur = ring_distance(oldest_index_reg, write_index_reg, length_reg);
        done_cur = ring_distance(oldest_index_reg, read_ahead_index_reg, length_reg);

        unique case (command)
            CMD_PUSH:
            begin
                if ((length_reg - used_cur) <= LEN_W'(1))
                    status_next = STATUS_FULL;
                else
                begin
                    mem_we           = 1'b1;
                    write_index_next = ring_next(write_index_reg, length_reg);
                end
            end
            CMD_POP:
            begin
                if (used_cur == '0)
                    status_next = STATUS_EMPTY;
                else
                begin
                    data_sel_next     = 1'b1;
                    oldest_index_next = ring_next(oldest_index_reg, length_reg);
                end
            end
            CMD_START_READ:
                read_ahead_index_next = oldest_index_reg;
            CMD_READ_AHEAD:
            begin
                rd_addr = read_ahead_index_reg;
                if (used_cur == '0)
                    status_next = STATUS_EMPTY;
                else if (done_cur >= used_cur)
                    status_next = STATUS_ALL_READ;
                else
                begin
                    data_sel_next         = 1'b1;
                    read_ahead_index_next = ring_next(read_ahead_index_reg, length_reg);
                end
            end
            CMD_END_READ:
                oldest_index_next = read_ahead_index_reg;
            default:
            begin
                // query and unused codes leave everything as it is
            end
        endcase

        used_new = ring_distance(oldest_index_next, write_index_next, length_reg);
        done_new = ring_distance(oldest_index_next, read_ahead_index_next, length_reg);

        used_next = used_new[7:0];
        free_next = length_reg - used_new;
        if (used_new == '0 || done_new >= used_new)
            unread_next = '0;
        else
            unread_next = 8'(used_new - done_new);
    end

    // ring indices and length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg           <= LEN_RESET;
            write_index_reg      <= '0;
            oldest_index_reg     <= '0;
            read_ahead_index_reg <= '0;
        end
        else if (config_write_en)
        begin
            length_reg           <= clamp_length(config_write_data);
            write_index_reg      <= '0;
            oldest_index_reg     <= '0;
            read_ahead_index_reg <= '0;
        end
        else if (in_accept)
        begin
            write_index_reg      <= write_index_next;
            oldest_index_reg     <= oldest_index_next;
            read_ahead_index_reg <= read_ahead_index_next;
        end
    end

    // byte store
    always_ff @(posedge clk)
    begin
        if (in_accept && mem_we && !config_write_en)
            byte_store[write_index_reg] <= push_data;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            rd_data_reg <= byte_store[rd_addr];
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            data_sel_reg <= data_sel_next;
            status_reg   <= status_next;
            used_reg     <= used_next;
            free_reg     <= free_next;
            unread_reg   <= unread_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_out     = data_sel_reg ? rd_data_reg : 8'd0;
    assign status       = status_reg;
    assign used_count   = used_reg;
    assign free_count   = free_reg;
    assign unread_count = unread_reg;

    // indices stay inside the length in use
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, write_index_reg} < length_reg) &&
        ({1'b0, oldest_index_reg} < length_reg) &&
        ({1'b0, read_ahead_index_reg} < length_reg))
        else $error("ring index beyond buffer length");

    // a rejected push only happens with at most one byte free
    a_full_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == STATUS_FULL) |-> (free_reg <= 9'd1))
        else $error("push rejected with room left");

    // returned data only on a successful pop or read
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && data_sel_reg |-> (status_reg == STATUS_OK))
        else $error("data returned with error status");

    // unread bytes never exceed held bytes
    a_unread_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (unread_reg <= used_reg))
        else $error("unread count above used count");

    // counts add up to the length in use after every accepted command
    a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !config_write_en |=>
            ({1'b0, used_reg} + free_reg == length_reg))
        else $error("used and free counts do not add up");

endmodule
`default_nettype wire

[tb/sv/tb_byte_ring_with_read_ahead.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_ring_with_read_ahead
// Self-checking bench for the byte ring with read-ahead. Commands are sent
// over the stall handshake with random gaps on both sides. A ring model held
// in the bench predicts every result beat, and each beat is compared field by
// field. The run covers a directed part, a long receiver hold-off that fills
// the ring, and random traffic over several ring lengths.
// ----------------------------------------------------------------------------
module tb_byte_ring_with_read_ahead;
    import brra_pkg::*;

    localparam logic [2:0] CMD_SPARE_A    = 3'd6;
    localparam logic [2:0] CMD_SPARE_B    = 3'd7;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 4;

    typedef struct {
        logic [7:0] data;
        status_t    stat;
        logic [7:0] used;
        logic [8:0] free;
        logic [7:0] unread;
    } ring_result_t;

    logic             clk;
    logic             rst_n;
    logic             config_write_en;
    logic [LEN_W-1:0] config_write_data;
    logic             in_valid;
    logic             in_stall;
    logic [2:0]       command;
    logic [7:0]       push_data;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       data_out;
    logic [1:0]       status;
    logic [7:0]       used_count;
    logic [8:0]       free_count;
    logic [7:0]       unread_count;

    // bench copy of the ring
    logic [7:0]       ring_store [STORE_DEPTH];
    bit               written_map [STORE_DEPTH];
    logic [IDX_W-1:0] write_idx  = '0;
    logic [IDX_W-1:0] oldest_idx = '0;
    logic [IDX_W-1:0] ahead_idx  = '0;
    logic [LEN_W-1:0] ring_len   = LEN_RESET;

    ring_result_t     expected_results [$];
    int               mismatch_count = 0;
    int               beats_sent     = 0;
    bit               tx_idle        = 1'b0;
    bit               rx_idle        = 1'b0;
    int               rx_hold_cycles = 0;

    byte_ring_with_read_ahead i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .config_write_en   (config_write_en),
        .config_write_data (config_write_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .push_data         (push_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .data_out          (data_out),
        .status            (status),
        .used_count        (used_count),
        .free_count        (free_count),
        .unread_count      (unread_count)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [LEN_W-1:0] ring_span(input logic [IDX_W-1:0] from_idx,
                                                   input logic [IDX_W-1:0] to_idx);
        if (to_idx >= from_idx)
            return {1'b0, to_idx} - {1'b0, from_idx};
        return {1'b0, to_idx} + ring_len - {1'b0, from_idx};
    endfunction

    function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx);
        if ({1'b0, idx} + LEN_W'(1) >= ring_len)
            return '0;
        return idx + IDX_W'(1);
    endfunction

    // a pop or read-ahead must never land on a byte that was never pushed
    function automatic bit fetch_is_safe(input logic [2:0] cmd);
        logic [LEN_W-1:0] held;
        logic [LEN_W-1:0] passed;
        held   = ring_span(oldest_idx, write_idx);
        passed = ring_span(oldest_idx, ahead_idx);
        if (cmd == CMD_POP && held != 0)
            return written_map[oldest_idx];
        if (cmd == CMD_READ_AHEAD && held != 0 && passed < held)
            return written_map[ahead_idx];
        return 1'b1;
    endfunction

    function automatic void predict_beat(input logic [2:0] cmd, input logic [7:0] byte_val);
        ring_result_t     res;
        logic [LEN_W-1:0] held;
        logic [LEN_W-1:0] passed;
        res.data = '0;
        res.stat = STATUS_OK;
        held     = ring_span(oldest_idx, write_idx);
        passed   = ring_span(oldest_idx, ahead_idx);
        case (cmd)
            CMD_PUSH:
                if (ring_len - held <= 1)
                    res.stat = STATUS_FULL;
                else
                begin
                    ring_store[write_idx]  = byte_val;
                    written_map[write_idx] = 1'b1;
                    write_idx              = ring_advance(write_idx);
                end
            CMD_POP:
                if (held == 0)
                    res.stat = STATUS_EMPTY;
                else
                begin
                    res.data   = ring_store[oldest_idx];
                    oldest_idx = ring_advance(oldest_idx);
                end
            CMD_START_READ:
                ahead_idx = oldest_idx;
            CMD_READ_AHEAD:
                if (held == 0)
                    res.stat = STATUS_EMPTY;
                else if (passed >= held)
                    res.stat = STATUS_ALL_READ;
                else
                begin
                    res.data  = ring_store[ahead_idx];
                    ahead_idx = ring_advance(ahead_idx);
                end
            CMD_END_READ:
                oldest_idx = ahead_idx;
            default:
                ;
        endcase
        held       = ring_span(oldest_idx, write_idx);
        passed     = ring_span(oldest_idx, ahead_idx);
        res.used   = held[7:0];
        res.free   = ring_len - held;
        res.unread = (held == 0 || passed >= held) ? 8'd0 : 8'(held - passed);
        expected_results.push_back(res);
    endfunction

    function automatic void check_field(input string field, input logic [8:0] want,
                                        input logic [8:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_beat(input logic [2:0] cmd, input logic [7:0] byte_val);
        int         gap;
        logic [2:0] sent_cmd;
        sent_cmd = fetch_is_safe(cmd) ? cmd : CMD_QUERY;
        gap      = tx_idle ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        command   <= sent_cmd;
        push_data <= byte_val;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_beat(sent_cmd, byte_val);
        beats_sent++;
    endtask

    task automatic finish_phase();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] value);
        finish_phase();
        @(negedge clk);
        config_write_en   <= 1'b1;
        config_write_data <= value;
        @(negedge clk);
        config_write_en <= 1'b0;
        if (value < LEN_MIN)
            ring_len = LEN_MIN;
        else if (value > LEN_MAX)
            ring_len = LEN_MAX;
        else
            ring_len = value;
        write_idx  = '0;
        oldest_idx = '0;
        ahead_idx  = '0;
    endtask

    task automatic test_empty_ring();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_beat(CMD_QUERY, 8'h00);
        send_beat(CMD_SPARE_A, 8'hFF);
        send_beat(CMD_SPARE_B, 8'h00);
        send_beat(CMD_POP, 8'h00);
        send_beat(CMD_READ_AHEAD, 8'h00);
        send_beat(CMD_START_READ, 8'h00);
        send_beat(CMD_END_READ, 8'h00);
        finish_phase();
    endtask

    task automatic test_read_ahead_session();
        send_beat(CMD_PUSH, 8'h00);
        send_beat(CMD_PUSH, 8'hFF);
        send_beat(CMD_START_READ, 8'h00);
        send_beat(CMD_READ_AHEAD, 8'h00);
        send_beat(CMD_READ_AHEAD, 8'h00);
        send_beat(CMD_READ_AHEAD, 8'h00);
        send_beat(CMD_END_READ, 8'h00);
        finish_phase();
    endtask

    // pop past the read-ahead pointer, then commit the lagging pointer
    task automatic test_stale_read_ahead();
        write_length(LEN_RESET);
        send_beat(CMD_PUSH, 8'h5A);
        send_beat(CMD_PUSH, 8'hA5);
        send_beat(CMD_START_READ, 8'h00);
        send_beat(CMD_POP, 8'h00);
        send_beat(CMD_READ_AHEAD, 8'h00);
        send_beat(CMD_END_READ, 8'h00);
        send_beat(CMD_POP, 8'h00);
        finish_phase();
    endtask

    task automatic test_shortest_ring();
        write_length(LEN_W'(1));
        send_beat(CMD_PUSH, 8'h11);
        send_beat(CMD_PUSH, 8'h22);
        send_beat(CMD_POP, 8'h00);
        send_beat(CMD_POP, 8'h00);
        finish_phase();
    endtask

    task automatic test_back_pressure();
        write_length(LEN_MAX);
        tx_idle        = 1'b0;
        rx_idle        = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (STORE_DEPTH + 2) send_beat(CMD_PUSH, 8'($urandom_range(0, 255)));
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (STORE_DEPTH + 1) send_beat(CMD_POP, 8'h00);
        finish_phase();
    endtask

    task automatic test_random_traffic(input logic [LEN_W-1:0] length_value, input int beats,
                                       input bit tx_gaps, input bit rx_gaps);
        int target;
        int pick;
        int burst;
        write_length(length_value);
        tx_idle = tx_gaps;
        rx_idle = rx_gaps;
        target  = beats_sent + beats;
        while (beats_sent < target)
        begin
            pick  = $urandom_range(0, 9);
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(1, ring_len + 2)
                                                : $urandom_range(1, 6);
            if (pick < 4)
                repeat (burst) send_beat(CMD_PUSH, 8'($urandom_range(0, 255)));
            else if (pick < 6)
                repeat (burst) send_beat(CMD_POP, 8'($urandom_range(0, 255)));
            else if (pick < 8)
            begin
                send_beat(CMD_START_READ, 8'($urandom_range(0, 255)));
                repeat (burst) send_beat(CMD_READ_AHEAD, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 2) != 0)
                    send_beat(CMD_END_READ, 8'($urandom_range(0, 255)));
            end
            else
                send_beat(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        end
        finish_phase();
    endtask

    // result side: random stall per beat, plus the long hold-off on request
    initial
    begin : result_drain
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_idle ? $urandom_range(0, 13) : 0;
            if (rx_hold_cycles > 0)
            begin
                gap            = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid === 1'b1 && out_stall === 1'b0))
                @(posedge clk);
        end
    end

    initial
    begin : result_check
        ring_result_t want;
        logic         got;
        logic [7:0]   got_data;
        logic [1:0]   got_status;
        logic [7:0]   got_used;
        logic [8:0]   got_free;
        logic [7:0]   got_unread;
        forever
        begin
            @(posedge clk);
            got        = (out_valid === 1'b1) && (out_stall === 1'b0);
            got_data   = data_out;
            got_status = status;
            got_used   = used_count;
            got_free   = free_count;
            got_unread = unread_count;
            @(negedge clk);
            if (got)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("data_out", want.data, got_data);
                    check_field("status", want.stat, got_status);
                    check_field("used_count", want.used, got_used);
                    check_field("free_count", want.free, got_free);
                    check_field("unread_count", want.unread, got_unread);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n             = 1'b0;
        config_write_en   = 1'b0;
        config_write_data = '0;
        in_valid          = 1'b0;
        command           = CMD_QUERY;
        push_data         = 8'h00;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_ring();
        test_read_ahead_session();
        test_stale_read_ahead();
        test_shortest_ring();
        test_back_pressure();
        test_random_traffic(LEN_W'(2), 50, 1'b1, 1'b1);
        test_random_traffic(LEN_W'(3), 50, 1'b0, 1'b0);
        test_random_traffic(LEN_W'(17), 90, 1'b1, 1'b0);
        test_random_traffic(LEN_W'(0), 30, 1'b0, 1'b1);
        test_random_traffic(LEN_W'(511), 100, 1'b1, 1'b1);
        test_random_traffic(LEN_W'(255), 70, 1'b0, 1'b0);
        test_random_traffic(LEN_W'(1), 20, 1'b1, 1'b1);
        test_random_traffic(LEN_W'(300), 50, 1'b1, 1'b1);
        test_random_traffic(LEN_W'(64), 70, 1'b1, 1'b0);

        finish_phase();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
